[sv/nswg_pkg.sv]
// Shared types, constants and helpers of the no-slip wall ghost-state block.
`timescale 1ns / 1ps

package nswg_pkg;

    localparam int WORD_W    = 32;
    localparam int GAMMA_W   = 19;
    localparam int CFG_IDX_W = 3;
    localparam int SAT_W     = 68;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREE_D   = 3'd0,
        CFG_GAS_GAMMA = 3'd1,
        CFG_WALL_X    = 3'd2,
        CFG_WALL_Y    = 3'd3,
        CFG_WALL_Z    = 3'd4
    } cfg_index_t;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd91750;

    localparam logic signed [SAT_W-1:0] SAT_MAX = 68'sd2147483647;
    localparam logic signed [SAT_W-1:0] SAT_MIN = -68'sd2147483648;

    // Clamp a wide signed value into the 32-bit signed range
    function automatic word_t sat32(input logic signed [SAT_W-1:0] x);
        word_t r;
        if (x > SAT_MAX)
            r = word_t'(SAT_MAX);
        else if (x < SAT_MIN)
            r = word_t'(SAT_MIN);
        else
            r = x[WORD_W-1:0];
        return r;
    endfunction

    // Magnitude of a 32-bit signed word; the most negative value maps to 2^31
    function automatic logic [WORD_W-1:0] mag32(input word_t x);
        logic [WORD_W-1:0] r;
        r = x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
        return r;
    endfunction

endpackage

[sv/nswg_point_if.sv]
// Input channel carrying one interior grid point per word.
`timescale 1ns / 1ps

interface nswg_point_if import nswg_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t density;
    word_t momentum_x;
    word_t momentum_y;
    word_t momentum_z;
    word_t total_energy;

    modport source (output valid, density, momentum_x, momentum_y, momentum_z,
                    total_energy, input ready);
    modport sink (input valid, density, momentum_x, momentum_y, momentum_z,
                  total_energy, output ready);
endinterface

[sv/nswg_ghost_if.sv]
// Output channel carrying one ghost-point state per word.
`timescale 1ns / 1ps

interface nswg_ghost_if import nswg_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t ghost_density;
    word_t ghost_momentum_x;
    word_t ghost_momentum_y;
    word_t ghost_momentum_z;
    word_t ghost_energy;
    logic  density_fault;

    modport source (output valid, ghost_density, ghost_momentum_x, ghost_momentum_y,
                    ghost_momentum_z, ghost_energy, density_fault, input ready);
    modport sink (input valid, ghost_density, ghost_momentum_x, ghost_momentum_y,
                  ghost_momentum_z, ghost_energy, density_fault, output ready);
endinterface

[sv/nswg_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps

module nswg_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [PW-1:0] payload_in,
    output logic          out_valid,
    output logic [NW-1:0] quotient,
    output logic [PW-1:0] payload_out
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] d_reg   [NW];
    logic [PW-1:0] pay_reg [NW];
    logic          vld_reg [NW];

    genvar s;
    for (s = 0; s < NW; s++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] d_in;
        logic [NW-1:0] nq_in;
        logic [PW-1:0] pay_in;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign d_in   = divisor;
            assign nq_in  = dividend;
            assign pay_in = payload_in;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign d_in   = d_reg[s-1];
            assign nq_in  = nq_reg[s-1];
            assign pay_in = pay_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        // Shift in the next dividend bit and try the subtraction
        assign trial = {rem_in, nq_in[NW-1]};
        assign ge    = trial >= {1'b0, d_in};

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_in;
        end

        // Advance remainder, quotient bits and sideband
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
                nq_reg[s]  <= {nq_in[NW-2:0], ge};
                d_reg[s]   <= d_in;
                pay_reg[s] <= pay_in;
            end
        end
    end

    assign out_valid   = vld_reg[NW-1];
    assign quotient    = nq_reg[NW-1];
    assign payload_out = pay_reg[NW-1];

endmodule

[sv/noslip_wall_ghost_state_top.sv]
// No-slip wall ghost state: mirrors an interior conserved state about a moving wall.
//
// Channels: point (sink) takes one interior state per word, ghost (source)
// gives one ghost state per word, both valid/ready. A word is taken when
// valid and ready are high at a rising edge. Configuration is a plain write
// port (cfg_we, cfg_index, cfg_data), to be written only while no word is
// in flight.
// Throughput: one word per cycle unless the output stalls. From acceptance
// to ghost.valid a word passes the two bit-per-stage dividers (velocity =
// momentum/density, and pressure/(gamma-1)), each 32+FRAC_BITS stages, and
// ten more stages: input register, arithmetic stages and output register.
// All stages move together; point.ready is low only while a result waits in
// the output register and ghost.ready is low, so a stall holds every stage
// and nothing is dropped or repeated. Bubbles are carried as invalid stages.
// Reset clears all valid bits and sets the registers to 2D, gamma 1.4 and a
// resting wall.
`timescale 1ns / 1ps

module noslip_wall_ghost_state_top import nswg_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    nswg_point_if.sink           point,
    nswg_ghost_if.source         ghost
);

    localparam int NW   = WORD_W + FRAC_BITS;
    localparam int GP_W = GAMMA_W + 1 + WORD_W;
    localparam int P1_W = 1 + 2 * WORD_W + 1;
    localparam int P2_W = 1 + 64 + 4 * WORD_W + 1;

    // Configuration registers
    logic               three_d_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    word_t              wall_x_reg;
    word_t              wall_y_reg;
    word_t              wall_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_d_reg <= 1'b0;
            gamma_reg   <= GAMMA_RESET;
            wall_x_reg  <= '0;
            wall_y_reg  <= '0;
            wall_z_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THREE_D:   three_d_reg <= cfg_data[0];
                CFG_GAS_GAMMA: gamma_reg   <= cfg_data[GAMMA_W-1:0];
                CFG_WALL_X:    wall_x_reg  <= cfg_data;
                CFG_WALL_Y:    wall_y_reg  <= cfg_data;
                CFG_WALL_Z:    wall_z_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Form gamma - 1, clamped below at one LSB
    logic signed [33:0]  gdiff;
    logic [GAMMA_W-1:0]  gm1;
    assign gdiff = $signed({15'd0, gamma_reg}) - (34'sd1 <<< FRAC_BITS);
    assign gm1   = (gdiff < 34'sd1) ? GAMMA_W'(1) : gdiff[GAMMA_W-1:0];

    // Whole pipeline advances unless the output word is held
    logic out_vld_reg;
    logic adv;
    assign adv         = !out_vld_reg || ghost.ready;
    assign point.ready = adv;

    // Input stage
    logic  s0_vld_reg, s0_fault_reg;
    word_t s0_rho_reg, s0_mx_reg, s0_my_reg, s0_mz_reg, s0_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (adv)
            s0_vld_reg <= point.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_rho_reg   <= point.density;
            s0_mx_reg    <= point.momentum_x;
            s0_my_reg    <= point.momentum_y;
            s0_mz_reg    <= three_d_reg ? point.momentum_z : '0;
            s0_e_reg     <= point.total_energy;
            s0_fault_reg <= (point.density[WORD_W-1] || point.density == '0);
        end
    end

    // Velocity dividers, one lane per component
    logic [WORD_W-1:0] rho_div;
    assign rho_div = s0_fault_reg ? WORD_W'(1) : WORD_W'(s0_rho_reg);

    logic            d1_vld, d1y_vld, d1z_vld;
    logic [NW-1:0]   qx, qy, qz;
    logic [P1_W-1:0] d1_pay;
    logic            d1y_neg, d1z_neg;

    nswg_div #(.NW(NW), .DW(WORD_W), .PW(P1_W)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s0_vld_reg),
        .dividend({mag32(s0_mx_reg), {FRAC_BITS{1'b0}}}), .divisor(rho_div),
        .payload_in({s0_mx_reg[WORD_W-1], s0_rho_reg, s0_e_reg, s0_fault_reg}),
        .out_valid(d1_vld), .quotient(qx), .payload_out(d1_pay)
    );

    nswg_div #(.NW(NW), .DW(WORD_W), .PW(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s0_vld_reg),
        .dividend({mag32(s0_my_reg), {FRAC_BITS{1'b0}}}), .divisor(rho_div),
        .payload_in(s0_my_reg[WORD_W-1]),
        .out_valid(d1y_vld), .quotient(qy), .payload_out(d1y_neg)
    );

    nswg_div #(.NW(NW), .DW(WORD_W), .PW(1)) u_div_z (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(s0_vld_reg),
        .dividend({mag32(s0_mz_reg), {FRAC_BITS{1'b0}}}), .divisor(rho_div),
        .payload_in(s0_mz_reg[WORD_W-1]),
        .out_valid(d1z_vld), .quotient(qz), .payload_out(d1z_neg)
    );

    // Apply sign to an unsigned quotient and saturate
    function automatic word_t quot_sat(input logic [NW-1:0] q, input logic neg);
        logic signed [NW:0] qs;
        qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return sat32(SAT_W'(qs));
    endfunction

    logic  d1x_neg, d1_fault;
    word_t d1_rho, d1_e;
    assign {d1x_neg, d1_rho, d1_e, d1_fault} = d1_pay;

    // Stage valid bits
    logic m1_vld_reg, m2_vld_reg, m3_vld_reg, m4_vld_reg;
    logic m5_vld_reg, m6_vld_reg, m7_vld_reg, m8_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            m5_vld_reg <= 1'b0;
            m6_vld_reg <= 1'b0;
            m7_vld_reg <= 1'b0;
            m8_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg <= d1_vld && d1y_vld && d1z_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
            m5_vld_reg <= m4_vld_reg;
            m6_vld_reg <= m5_vld_reg;
            m7_vld_reg <= m6_vld_reg;
            m8_vld_reg <= m7_vld_reg;
        end
    end

    // Stage 1: signed saturated velocities
    word_t m1_u_reg, m1_v_reg, m1_w_reg, m1_rho_reg, m1_e_reg;
    logic  m1_fault_reg;
    // Stage 2: mirrored velocities
    word_t m2_u_reg, m2_v_reg, m2_w_reg, m2_ug_reg, m2_vg_reg, m2_wg_reg;
    word_t m2_rho_reg, m2_e_reg;
    logic  m2_fault_reg;
    // Stage 3: products and squares
    logic signed [63:0] m3_su_reg, m3_sv_reg, m3_sw_reg;
    logic signed [63:0] m3_sgu_reg, m3_sgv_reg, m3_sgw_reg;
    logic signed [63:0] m3_pmx_reg, m3_pmy_reg, m3_pmz_reg;
    word_t m3_rho_reg, m3_e_reg;
    logic  m3_fault_reg;
    // Stage 4: squared speeds and ghost momenta
    logic [WORD_W-1:0] m4_sq_reg, m4_sqg_reg;
    word_t m4_mgx_reg, m4_mgy_reg, m4_mgz_reg, m4_rho_reg, m4_e_reg;
    logic  m4_fault_reg;
    // Stage 5: kinetic energies
    logic [63:0] m5_ke_reg, m5_keg_reg;
    word_t m5_mgx_reg, m5_mgy_reg, m5_mgz_reg, m5_rho_reg, m5_e_reg;
    logic  m5_fault_reg;
    // Stage 6: internal energy
    word_t m6_t_reg;
    logic [63:0] m6_keg_reg;
    word_t m6_mgx_reg, m6_mgy_reg, m6_mgz_reg, m6_rho_reg;
    logic  m6_fault_reg;
    // Stage 7: (gamma - 1) times internal energy
    logic signed [GP_W-1:0] m7_gp_reg;
    logic [63:0] m7_keg_reg;
    word_t m7_mgx_reg, m7_mgy_reg, m7_mgz_reg, m7_rho_reg;
    logic  m7_fault_reg;
    // Stage 8: pressure
    word_t m8_p_reg;
    logic [63:0] m8_keg_reg;
    word_t m8_mgx_reg, m8_mgy_reg, m8_mgz_reg, m8_rho_reg;
    logic  m8_fault_reg;

    // Combinational values between stages
    logic [63:0] sum_next, sumg_next, sh_next, shg_next;
    logic [63:0] kp_next, kpg_next;
    assign sum_next  = $unsigned(m3_su_reg) + $unsigned(m3_sv_reg) + $unsigned(m3_sw_reg);
    assign sumg_next = $unsigned(m3_sgu_reg) + $unsigned(m3_sgv_reg)
                     + $unsigned(m3_sgw_reg);
    assign sh_next   = sum_next >> FRAC_BITS;
    assign shg_next  = sumg_next >> FRAC_BITS;
    assign kp_next   = {32'd0, m4_rho_reg} * {32'd0, m4_sq_reg};
    assign kpg_next  = {32'd0, m4_rho_reg} * {32'd0, m4_sqg_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Sign and saturate velocities
            m1_u_reg     <= quot_sat(qx, d1x_neg);
            m1_v_reg     <= quot_sat(qy, d1y_neg);
            m1_w_reg     <= quot_sat(qz, d1z_neg);
            m1_rho_reg   <= d1_rho;
            m1_e_reg     <= d1_e;
            m1_fault_reg <= d1_fault;

            // Mirror about the wall velocity; drop z in 2D
            m2_u_reg     <= m1_u_reg;
            m2_v_reg     <= m1_v_reg;
            m2_w_reg     <= m1_w_reg;
            m2_ug_reg    <= sat32((SAT_W'(wall_x_reg) <<< 1) - SAT_W'(m1_u_reg));
            m2_vg_reg    <= sat32((SAT_W'(wall_y_reg) <<< 1) - SAT_W'(m1_v_reg));
            m2_wg_reg    <= three_d_reg
                          ? sat32((SAT_W'(wall_z_reg) <<< 1) - SAT_W'(m1_w_reg)) : '0;
            m2_rho_reg   <= m1_rho_reg;
            m2_e_reg     <= m1_e_reg;
            m2_fault_reg <= m1_fault_reg;

            // Multiply
            m3_su_reg    <= m2_u_reg * m2_u_reg;
            m3_sv_reg    <= m2_v_reg * m2_v_reg;
            m3_sw_reg    <= m2_w_reg * m2_w_reg;
            m3_sgu_reg   <= m2_ug_reg * m2_ug_reg;
            m3_sgv_reg   <= m2_vg_reg * m2_vg_reg;
            m3_sgw_reg   <= m2_wg_reg * m2_wg_reg;
            m3_pmx_reg   <= m2_rho_reg * m2_ug_reg;
            m3_pmy_reg   <= m2_rho_reg * m2_vg_reg;
            m3_pmz_reg   <= m2_rho_reg * m2_wg_reg;
            m3_rho_reg   <= m2_rho_reg;
            m3_e_reg     <= m2_e_reg;
            m3_fault_reg <= m2_fault_reg;

            // Sum squares, clamp to 32 bits unsigned; scale ghost momenta
            m4_sq_reg    <= (|sh_next[63:WORD_W]) ? '1 : sh_next[WORD_W-1:0];
            m4_sqg_reg   <= (|shg_next[63:WORD_W]) ? '1 : shg_next[WORD_W-1:0];
            m4_mgx_reg   <= sat32(SAT_W'(m3_pmx_reg >>> FRAC_BITS));
            m4_mgy_reg   <= sat32(SAT_W'(m3_pmy_reg >>> FRAC_BITS));
            m4_mgz_reg   <= sat32(SAT_W'(m3_pmz_reg >>> FRAC_BITS));
            m4_rho_reg   <= m3_rho_reg;
            m4_e_reg     <= m3_e_reg;
            m4_fault_reg <= m3_fault_reg;

            // Half density times squared speed
            m5_ke_reg    <= kp_next >> (FRAC_BITS + 1);
            m5_keg_reg   <= kpg_next >> (FRAC_BITS + 1);
            m5_mgx_reg   <= m4_mgx_reg;
            m5_mgy_reg   <= m4_mgy_reg;
            m5_mgz_reg   <= m4_mgz_reg;
            m5_rho_reg   <= m4_rho_reg;
            m5_e_reg     <= m4_e_reg;
            m5_fault_reg <= m4_fault_reg;

            // Subtract kinetic part from total energy
            m6_t_reg     <= sat32(SAT_W'(m5_e_reg) - SAT_W'($signed(m5_ke_reg)));
            m6_keg_reg   <= m5_keg_reg;
            m6_mgx_reg   <= m5_mgx_reg;
            m6_mgy_reg   <= m5_mgy_reg;
            m6_mgz_reg   <= m5_mgz_reg;
            m6_rho_reg   <= m5_rho_reg;
            m6_fault_reg <= m5_fault_reg;

            // Scale by gamma - 1
            m7_gp_reg    <= $signed({1'b0, gm1}) * m6_t_reg;
            m7_keg_reg   <= m6_keg_reg;
            m7_mgx_reg   <= m6_mgx_reg;
            m7_mgy_reg   <= m6_mgy_reg;
            m7_mgz_reg   <= m6_mgz_reg;
            m7_rho_reg   <= m6_rho_reg;
            m7_fault_reg <= m6_fault_reg;

            // Pressure
            m8_p_reg     <= sat32(SAT_W'(m7_gp_reg >>> FRAC_BITS));
            m8_keg_reg   <= m7_keg_reg;
            m8_mgx_reg   <= m7_mgx_reg;
            m8_mgy_reg   <= m7_mgy_reg;
            m8_mgz_reg   <= m7_mgz_reg;
            m8_rho_reg   <= m7_rho_reg;
            m8_fault_reg <= m7_fault_reg;
        end
    end

    // Pressure over gamma - 1
    logic            d2_vld;
    logic [NW-1:0]   qp;
    logic [P2_W-1:0] d2_pay;

    nswg_div #(.NW(NW), .DW(GAMMA_W), .PW(P2_W)) u_div_p (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(m8_vld_reg),
        .dividend({mag32(m8_p_reg), {FRAC_BITS{1'b0}}}), .divisor(gm1),
        .payload_in({m8_p_reg[WORD_W-1], m8_keg_reg, m8_mgx_reg, m8_mgy_reg,
                     m8_mgz_reg, m8_rho_reg, m8_fault_reg}),
        .out_valid(d2_vld), .quotient(qp), .payload_out(d2_pay)
    );

    logic        d2_neg, d2_fault;
    logic [63:0] d2_keg;
    word_t       d2_mgx, d2_mgy, d2_mgz, d2_rho;
    assign {d2_neg, d2_keg, d2_mgx, d2_mgy, d2_mgz, d2_rho, d2_fault} = d2_pay;

    logic signed [NW:0]      qp_signed;
    logic signed [SAT_W-1:0] eg_sum;
    assign qp_signed = d2_neg ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
    assign eg_sum    = SAT_W'(qp_signed) + SAT_W'($signed(d2_keg));

    // Output register
    word_t out_rho_reg, out_mgx_reg, out_mgy_reg, out_mgz_reg, out_eg_reg;
    logic  out_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_fault_reg <= d2_fault;
            out_rho_reg   <= d2_fault ? '0 : d2_rho;
            out_mgx_reg   <= d2_fault ? '0 : d2_mgx;
            out_mgy_reg   <= d2_fault ? '0 : d2_mgy;
            out_mgz_reg   <= d2_fault ? '0 : d2_mgz;
            out_eg_reg    <= d2_fault ? '0 : sat32(eg_sum);
        end
    end

    assign ghost.valid            = out_vld_reg;
    assign ghost.ghost_density    = out_rho_reg;
    assign ghost.ghost_momentum_x = out_mgx_reg;
    assign ghost.ghost_momentum_y = out_mgy_reg;
    assign ghost.ghost_momentum_z = out_mgz_reg;
    assign ghost.ghost_energy     = out_eg_reg;
    assign ghost.density_fault    = out_fault_reg;

endmodule

[sv/nswg_checker.sv]
// Port-level checks of the ghost-state block, bound to its top level.
`timescale 1ns / 1ps

module nswg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        point_ready,
    input logic        ghost_valid,
    input logic        ghost_ready,
    input logic [31:0] ghost_density,
    input logic [31:0] ghost_momentum_x,
    input logic [31:0] ghost_momentum_y,
    input logic [31:0] ghost_momentum_z,
    input logic [31:0] ghost_energy,
    input logic        density_fault
);

    // Hold a stalled word
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ghost_valid && !ghost_ready |=> ghost_valid)
        else $error("ghost word dropped while stalled");

    // Stop taking words while the output is stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        ghost_valid && !ghost_ready |-> !point_ready)
        else $error("input taken while output stalled");

    // Zero every field of a faulted word
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ghost_valid && density_fault |-> ghost_density == 32'd0
            && ghost_momentum_x == 32'd0 && ghost_momentum_y == 32'd0
            && ghost_momentum_z == 32'd0 && ghost_energy == 32'd0)
        else $error("faulted word carries data");

    // Copy only positive density
    a_density_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ghost_valid && !density_fault |-> !ghost_density[31] && ghost_density != 32'd0)
        else $error("non-positive density without fault");

endmodule

bind noslip_wall_ghost_state_top nswg_checker u_nswg_checker (
    .clk(clk),
    .rst_n(rst_n),
    .point_ready(point.ready),
    .ghost_valid(ghost.valid),
    .ghost_ready(ghost.ready),
    .ghost_density(ghost.ghost_density),
    .ghost_momentum_x(ghost.ghost_momentum_x),
    .ghost_momentum_y(ghost.ghost_momentum_y),
    .ghost_momentum_z(ghost.ghost_momentum_z),
    .ghost_energy(ghost.ghost_energy),
    .density_fault(ghost.density_fault)
);
